@@ src/psd_pkg.sv @@
// Package with shared types and constants of the program stream demultiplexer.
package psd_pkg;

    typedef enum logic [3:0] {
        PH_HUNT    = 4'd0,
        PH_LEN_HI  = 4'd1,
        PH_LEN_LO  = 4'd2,
        PH_STUFF   = 4'd3,
        PH_STD     = 4'd4,
        PH_CODE    = 4'd5,
        PH_TS      = 4'd6,
        PH_DTS1    = 4'd7,
        PH_FLAGS   = 4'd8,
        PH_HLEN    = 4'd9,
        PH_HDR     = 4'd10,
        PH_SUBID   = 4'd11,
        PH_AUDHDR  = 4'd12,
        PH_PCM     = 4'd13,
        PH_PAYLOAD = 4'd14,
        PH_SKIP    = 4'd15
    } t_phase;

    typedef enum logic [1:0] {
        LK_NONE = 2'd0,
        LK_PACK = 2'd1,
        LK_SYNC = 2'd2
    } t_lock;

    localparam logic [1:0] REG_AUDIO    = 2'd0;
    localparam logic [1:0] REG_VIDEO    = 2'd1;
    localparam logic [1:0] REG_SUBTITLE = 2'd2;

    localparam logic [1:0] KIND_VIDEO    = 2'd0;
    localparam logic [1:0] KIND_AUDIO    = 2'd1;
    localparam logic [1:0] KIND_SUBTITLE = 2'd2;

    localparam logic [31:0] WINDOW_RESET = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  number;
        logic [7:0]  data;
        logic        first;
        logic [31:0] stamp;
        logic        last;
    } t_result;

endpackage

@@ src/psd_parser.sv @@
// Byte parser: start code hunt, PES header parsing and payload selection.
module psd_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [7:0]         i_byte,
    input  logic [7:0]         i_audio_choice,
    input  logic [4:0]         i_video_choice,
    input  logic [5:0]         i_subtitle_choice,
    output logic               o_valid,
    output psd_pkg::t_result   o_result
);

    psd_pkg::t_phase r_phase, n_phase;
    psd_pkg::t_lock  r_lock, n_lock;
    logic [31:0] r_window, n_window;
    logic [15:0] r_left, n_left;
    logic [7:0]  r_hleft, n_hleft;
    logic [31:0] r_stamp, n_stamp;
    logic [3:0]  r_count, n_count;
    logic [7:0]  r_code, n_code;
    logic [7:0]  r_la, n_la;
    logic        r_al, n_al;
    logic [3:0]  r_lv, n_lv;
    logic        r_vl, n_vl;
    logic [15:0] r_pcm, n_pcm;
    logic        r_bad, n_bad, r_dts, n_dts, r_m2, n_m2, r_pts, n_pts, r_lpcm, n_lpcm;
    logic [1:0]  r_kind, n_kind;
    logic [7:0]  r_num, n_num;

    logic [7:0]  v;
    logic [15:0] dec;
    logic [31:0] win;
    logic [31:0] ts_val;
    logic        ts_badv;
    logic [2:0]  ts_idx;
    logic        ts_en;

    always_comb begin
        ts_val  = r_stamp;
        ts_badv = r_bad;
        case (ts_idx)
            3'd0: begin
                ts_val  = {v[2:1], 30'd0};
                ts_badv = ~v[0];
            end
            3'd1: ts_val = r_stamp | {2'd0, v, 22'd0};
            3'd2: begin
                ts_val = r_stamp | {10'd0, v[7:1], 15'd0};
                if (!v[0]) ts_badv = 1'b1;
            end
            3'd3: ts_val = r_stamp | {17'd0, v, 7'd0};
            default: begin
                ts_val = r_stamp | {25'd0, v[7:1]};
                if (!v[0]) ts_badv = 1'b1;
                if (ts_badv) ts_val = 32'd0;
            end
        endcase
    end

    always_comb begin
        logic [7:0] low;
        logic       hit;
        logic [7:0] an;
        logic [3:0] vn;
        v = i_byte;
        dec = r_left - 16'd1;
        win = {r_window[23:0], v};
        n_phase = r_phase; n_lock = r_lock; n_window = r_window; n_left = r_left;
        n_hleft = r_hleft; n_stamp = r_stamp; n_count = r_count; n_code = r_code;
        n_la = r_la; n_al = r_al; n_lv = r_lv; n_vl = r_vl; n_pcm = r_pcm;
        n_bad = r_bad; n_dts = r_dts; n_m2 = r_m2; n_pts = r_pts; n_lpcm = r_lpcm;
        n_kind = r_kind; n_num = r_num;
        o_valid = 1'b0;
        o_result = '{kind: r_kind, number: r_num, data: v, first: (r_count != 4'd0),
                     stamp: r_stamp, last: (dec == 16'd0)};
        ts_idx = 3'd0;
        ts_en = 1'b0;
        low = 8'd0; hit = 1'b0; an = 8'd0; vn = 4'd0;
        if (i_valid) begin
            // Shared length-count decrement for every phase after the length field, payload and skip included.
            if (r_phase != psd_pkg::PH_HUNT && r_phase != psd_pkg::PH_LEN_HI &&
                r_phase != psd_pkg::PH_LEN_LO) begin
                n_left = dec;
            end
            case (r_phase)
                psd_pkg::PH_HUNT: begin
                    n_window = win;
                    if (win[31:8] == 24'h000001) begin
                        n_window = psd_pkg::WINDOW_RESET;
                        low = win[7:0];
                        case (r_lock)
                            psd_pkg::LK_NONE: if (low == 8'hBA) n_lock = psd_pkg::LK_PACK;
                            psd_pkg::LK_PACK: begin
                                if (low == 8'hBB || low == 8'hBD ||
                                    (low >= 8'hC0 && low <= 8'hEF))
                                    n_lock = psd_pkg::LK_SYNC;
                                else
                                    n_lock = psd_pkg::LK_NONE;
                            end
                            default: ;
                        endcase
                        if (n_lock == psd_pkg::LK_SYNC && !(low < 8'hBC || low >= 8'hF0 ||
                            low == 8'hBE || low == 8'hBF)) begin
                            n_code = low;
                            n_phase = psd_pkg::PH_LEN_HI;
                        end
                    end
                end
                psd_pkg::PH_LEN_HI: begin
                    n_left = {v, 8'd0};
                    n_phase = psd_pkg::PH_LEN_LO;
                end
                psd_pkg::PH_LEN_LO: begin
                    n_left = {r_left[15:8], v};
                    if ({r_left[15:8], v} == 16'd0) begin
                        n_phase = psd_pkg::PH_HUNT;
                        n_window = psd_pkg::WINDOW_RESET;
                    end else begin
                        n_stamp = 32'd0; n_bad = 1'b0; n_m2 = 1'b0; n_pts = 1'b0;
                        n_phase = psd_pkg::PH_STUFF;
                    end
                end
                psd_pkg::PH_PAYLOAD: begin
                    o_valid = 1'b1;
                    n_count = 4'd0;
                    if (dec == 16'd0) begin
                        n_phase = psd_pkg::PH_HUNT;
                        n_window = psd_pkg::WINDOW_RESET;
                    end
                end
                psd_pkg::PH_SKIP: begin
                    if (dec == 16'd0) begin
                        n_phase = psd_pkg::PH_HUNT;
                        n_window = psd_pkg::WINDOW_RESET;
                    end
                end
                default: begin
                    if (dec == 16'd0) begin
                        n_phase = psd_pkg::PH_HUNT;
                        n_window = psd_pkg::WINDOW_RESET;
                    end else begin
                        // Header byte processing; "hit" means header complete.
                        case (r_phase)
                            psd_pkg::PH_STUFF, psd_pkg::PH_CODE: begin
                                if (r_phase == psd_pkg::PH_STUFF && v == 8'hFF) begin
                                end else if (r_phase == psd_pkg::PH_STUFF &&
                                             v[7:6] == 2'b01) begin
                                    n_phase = psd_pkg::PH_STD;
                                end else if (v[7:4] == 4'h2 || v[7:4] == 4'h3) begin
                                    ts_idx = 3'd0; ts_en = 1'b1;
                                    n_dts = v[4];
                                    n_count = 4'd1;
                                    n_phase = psd_pkg::PH_TS;
                                end else if (v[7:6] == 2'b10) begin
                                    n_m2 = 1'b1;
                                    n_phase = psd_pkg::PH_FLAGS;
                                end else if (v == 8'h0F) begin
                                    hit = 1'b1;
                                end else begin
                                    n_phase = psd_pkg::PH_HUNT;
                                    n_window = psd_pkg::WINDOW_RESET;
                                end
                            end
                            psd_pkg::PH_STD: n_phase = psd_pkg::PH_CODE;
                            psd_pkg::PH_TS: begin
                                ts_idx = r_count[2:0]; ts_en = 1'b1;
                                n_count = r_count + 4'd1;
                                if (r_count + 4'd1 >= 4'd5) begin
                                    if (r_dts) begin
                                        n_count = 4'd0;
                                        n_phase = psd_pkg::PH_DTS1;
                                    end else hit = 1'b1;
                                end
                            end
                            psd_pkg::PH_DTS1: begin
                                if (r_count == 4'd0 && v[7:4] != 4'h1) n_stamp = 32'd0;
                                n_count = r_count + 4'd1;
                                if (r_count + 4'd1 >= 4'd5) hit = 1'b1;
                            end
                            psd_pkg::PH_FLAGS: begin
                                n_pts = v[7];
                                n_phase = psd_pkg::PH_HLEN;
                            end
                            psd_pkg::PH_HLEN: begin
                                if ({8'd0, v} > dec) begin
                                    n_phase = psd_pkg::PH_HUNT;
                                    n_window = psd_pkg::WINDOW_RESET;
                                end else begin
                                    n_hleft = v;
                                    n_count = 4'd0;
                                    if (v < 8'd5) n_pts = 1'b0;
                                    if (v == 8'd0) hit = 1'b1;
                                    else n_phase = psd_pkg::PH_HDR;
                                end
                            end
                            psd_pkg::PH_HDR: begin
                                if (r_pts && r_count < 4'd5) begin
                                    ts_idx = r_count[2:0]; ts_en = 1'b1;
                                    n_count = r_count + 4'd1;
                                end
                                n_hleft = r_hleft - 8'd1;
                                if (r_hleft == 8'd1) hit = 1'b1;
                            end
                            psd_pkg::PH_SUBID: begin
                                an = (i_audio_choice < 8'd192) ? i_audio_choice :
                                     (r_al ? r_la : v);
                                if (dec < 16'd3) begin
                                    n_phase = psd_pkg::PH_HUNT;
                                    n_window = psd_pkg::WINDOW_RESET;
                                end else if (v[7:5] == 3'b001) begin
                                    if (i_subtitle_choice < 6'd32 &&
                                        {1'b0, v[4:0]} == i_subtitle_choice) begin
                                        n_kind = psd_pkg::KIND_SUBTITLE;
                                        n_num = {3'd0, v[4:0]};
                                        n_count = 4'd1;
                                        n_phase = psd_pkg::PH_PAYLOAD;
                                    end else n_phase = psd_pkg::PH_SKIP;
                                end else if (v[7:6] == 2'b10) begin
                                    if (i_audio_choice >= 8'd192 && !r_al) begin
                                        n_al = 1'b1; n_la = v;
                                    end
                                    if (v == an) begin
                                        n_num = v;
                                        n_lpcm = (v[7:5] == 3'b101);
                                        n_count = 4'd0;
                                        n_phase = psd_pkg::PH_AUDHDR;
                                    end else n_phase = psd_pkg::PH_SKIP;
                                end else n_phase = psd_pkg::PH_SKIP;
                            end
                            psd_pkg::PH_AUDHDR: begin
                                n_count = r_count + 4'd1;
                                if (r_count + 4'd1 >= 4'd3) begin
                                    if (r_lpcm && dec >= 16'd2) begin
                                        n_count = 4'd0; n_pcm = 16'd0;
                                        n_phase = psd_pkg::PH_PCM;
                                    end else begin
                                        n_kind = psd_pkg::KIND_AUDIO;
                                        n_count = 4'd1;
                                        n_phase = psd_pkg::PH_PAYLOAD;
                                    end
                                end
                            end
                            psd_pkg::PH_PCM: begin
                                n_pcm = {r_pcm[7:0], v};
                                if (r_count < 4'd2) n_count = r_count + 4'd1;
                                if (n_count >= 4'd2 && {r_pcm[7:0], v} == 16'h0180) begin
                                    n_kind = psd_pkg::KIND_AUDIO;
                                    n_count = 4'd1;
                                    n_phase = psd_pkg::PH_PAYLOAD;
                                end
                            end
                            default: ;
                        endcase
                        if (ts_en) begin
                            n_stamp = ts_val;
                            n_bad = ts_badv;
                        end
                        if (hit) begin
                            n_phase = psd_pkg::PH_SKIP;
                            if (n_m2 && r_code == 8'hBD) begin
                                n_phase = psd_pkg::PH_SUBID;
                            end else if (r_code >= 8'hC0 && r_code <= 8'hDF) begin
                                an = r_code - 8'hC0;
                                if (i_audio_choice < 8'd192) begin
                                    if (an == i_audio_choice) n_phase = psd_pkg::PH_PAYLOAD;
                                end else begin
                                    if (!r_al) begin n_al = 1'b1; n_la = an; end
                                    if (an == (r_al ? r_la : an))
                                        n_phase = psd_pkg::PH_PAYLOAD;
                                end
                                if (n_phase == psd_pkg::PH_PAYLOAD) begin
                                    n_kind = psd_pkg::KIND_AUDIO; n_num = an;
                                    n_count = 4'd1;
                                end
                            end else if (r_code >= 8'hE0 && r_code <= 8'hEF) begin
                                vn = r_code[3:0];
                                if (i_video_choice < 5'd16) begin
                                    if ({1'b0, vn} == i_video_choice)
                                        n_phase = psd_pkg::PH_PAYLOAD;
                                end else begin
                                    if (!r_vl) begin n_vl = 1'b1; n_lv = vn; end
                                    if (vn == (r_vl ? r_lv : vn))
                                        n_phase = psd_pkg::PH_PAYLOAD;
                                end
                                if (n_phase == psd_pkg::PH_PAYLOAD) begin
                                    n_kind = psd_pkg::KIND_VIDEO; n_num = {4'd0, vn};
                                    n_count = 4'd1;
                                end
                            end
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= psd_pkg::PH_HUNT; r_lock <= psd_pkg::LK_NONE;
            r_window <= psd_pkg::WINDOW_RESET; r_left <= 16'd0; r_hleft <= 8'd0;
            r_stamp <= 32'd0; r_count <= 4'd0; r_code <= 8'd0; r_la <= 8'd0;
            r_al <= 1'b0; r_lv <= 4'd0; r_vl <= 1'b0; r_pcm <= 16'd0;
            r_bad <= 1'b0; r_dts <= 1'b0; r_m2 <= 1'b0; r_pts <= 1'b0;
            r_lpcm <= 1'b0; r_kind <= 2'd0; r_num <= 8'd0;
        end else begin
            r_phase <= n_phase; r_lock <= n_lock; r_window <= n_window;
            r_left <= n_left; r_hleft <= n_hleft; r_stamp <= n_stamp;
            r_count <= n_count; r_code <= n_code; r_la <= n_la; r_al <= n_al;
            r_lv <= n_lv; r_vl <= n_vl; r_pcm <= n_pcm; r_bad <= n_bad;
            r_dts <= n_dts; r_m2 <= n_m2; r_pts <= n_pts; r_lpcm <= n_lpcm;
            r_kind <= n_kind; r_num <= n_num;
        end
    end

`ifndef SYNTHESIS
    a_out_only_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_phase == psd_pkg::PH_PAYLOAD) else $error("result outside payload");
    a_last_hunts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.last) |=> r_phase == psd_pkg::PH_HUNT)
        else $error("last byte did not end packet");
    a_parse_needs_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == psd_pkg::PH_LEN_HI) |-> r_lock == psd_pkg::LK_SYNC)
        else $error("parse without lock");
`endif

endmodule

@@ src/psd_fifo.sv @@
// Small result queue between the parser and the output port.
module psd_fifo #(
    parameter int Depth = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  psd_pkg::t_result  i_data,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_empty,
    output psd_pkg::t_result  o_data
);

    localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1;

    psd_pkg::t_result r_mem [Depth];
    logic [Aw-1:0] r_wr, r_rd;
    logic [Aw:0]   r_cnt;
    logic          push_ok, pop_ok;

    assign o_full  = (r_cnt == Aw'(0) + (Aw+1)'(Depth));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (push_ok) r_mem[r_wr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0; r_rd <= '0; r_cnt <= '0;
        end else begin
            if (push_ok) r_wr <= (r_wr == Aw'(Depth - 1)) ? '0 : r_wr + Aw'(1);
            if (pop_ok)  r_rd <= (r_rd == Aw'(Depth - 1)) ? '0 : r_rd + Aw'(1);
            r_cnt <= r_cnt + (Aw+1)'(push_ok) - (Aw+1)'(pop_ok);
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |=> r_cnt <= (Aw+1)'(Depth)) else $error("queue overflow");
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_ok && !pop_ok) |=> r_cnt == $past(r_cnt) + (Aw+1)'(1))
        else $error("queue count mismatch");
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> r_wr == r_rd) else $error("empty with pending data");
`endif

endmodule

@@ src/program_stream_pes_demux.sv @@
// Top level of the MPEG program stream PES demultiplexer.
// The input channel takes one program stream byte per transaction: drive
// i_data_byte with push high; a transaction completes when full is low.
// The result channel is a queue: while empty is low the oldest payload
// byte and its tags (kind, number, first, last, stamp) are on the o_ ports,
// and pop takes it.
// The parser handles one byte per cycle while full is low; a selected payload
// byte is registered into the result queue when the byte is accepted.
// Throughput is one byte per cycle while full is low, set by the combinational parse update.
// If the receiver stalls, results collect in a queue of Depth entries;
// when it is full, full stops the input until the receiver pops.
// Configuration registers are written through i_cfg_we, i_cfg_index and i_cfg_data;
// the user must write them only while the block is idle; the block itself does not enforce it.
// Synchronous reset clears the lock, the parser and the queue, and sets the
// stream choices to automatic audio and video and no subtitles.
module program_stream_pes_demux #(
    parameter int Depth = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_stream_kind,
    output logic [7:0]  o_stream_number,
    output logic [7:0]  o_payload_byte,
    output logic        o_first_of_packet,
    output logic [31:0] o_stamp,
    output logic        o_last_of_packet,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    logic [7:0] r_audio;
    logic [4:0] r_video;
    logic [5:0] r_sub;
    logic       acc, res_valid;
    psd_pkg::t_result res, head;

    assign acc = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_audio <= 8'd192; r_video <= 5'd16; r_sub <= 6'd32;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                psd_pkg::REG_AUDIO:    r_audio <= i_cfg_data;
                psd_pkg::REG_VIDEO:    r_video <= i_cfg_data[4:0];
                psd_pkg::REG_SUBTITLE: r_sub <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    psd_parser u_parser (
        .i_clk, .i_rst_n, .i_valid(acc), .i_byte(i_data_byte),
        .i_audio_choice(r_audio), .i_video_choice(r_video),
        .i_subtitle_choice(r_sub), .o_valid(res_valid), .o_result(res)
    );

    psd_fifo #(.Depth(Depth)) u_fifo (
        .i_clk, .i_rst_n, .i_push(res_valid), .i_data(res), .i_pop(pop),
        .o_full(full), .o_empty(empty), .o_data(head)
    );

    assign o_stream_kind     = head.kind;
    assign o_stream_number   = head.number;
    assign o_payload_byte    = head.data;
    assign o_first_of_packet = head.first;
    assign o_stamp           = head.stamp;
    assign o_last_of_packet  = head.last;

endmodule

@@ sim/psd_checker.sv @@
// Checker that predicts the demultiplexer's payload output and compares each result transaction.
`timescale 1ns / 100ps
module psd_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_empty,
    input  logic        i_pop,
    input  logic [1:0]  i_stream_kind,
    input  logic [7:0]  i_stream_number,
    input  logic [7:0]  i_payload_byte,
    input  logic        i_first_of_packet,
    input  logic [31:0] i_stamp,
    input  logic        i_last_of_packet,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    output int          o_errors,
    output int          o_pending
);

    logic [7:0]  audio_sel;
    logic [4:0]  video_sel;
    logic [5:0]  sub_sel;
    psd_pkg::t_lock   lock;
    logic [31:0] window;
    psd_pkg::t_phase  phase;
    logic [15:0] remaining;
    logic [7:0]  hdr_remaining;
    logic [31:0] pts;
    logic [3:0]  count;
    logic [7:0]  stream_id;
    logic [7:0]  auto_audio;
    logic        auto_audio_set;
    logic [3:0]  auto_video;
    logic        auto_video_set;
    logic [15:0] pcm_marker;
    logic        pts_bad, has_dts, is_mpeg2, pts_flag, is_lpcm;
    logic [1:0]  out_kind;
    logic [7:0]  out_num;
    psd_pkg::t_result payload_q[$];

    assign o_pending = payload_q.size();

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
        o_errors++;
    endtask

    function automatic void restart_hunt();
        phase  = psd_pkg::PH_HUNT;
        window = psd_pkg::WINDOW_RESET;
    endfunction

    function automatic logic consume();
        remaining = remaining - 16'd1;
        if (remaining == 16'd0) begin
            restart_hunt();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic pts_byte(input logic [3:0] idx, input logic [7:0] v);
        case (idx)
            4'd0: begin
                pts = {v[2:1], 30'd0};
                pts_bad = !v[0];
            end
            4'd1: pts = pts | ({24'd0, v} << 22);
            4'd2: begin
                pts = pts | ({25'd0, v[7:1]} << 15);
                if (!v[0]) pts_bad = 1'b1;
            end
            4'd3: pts = pts | ({24'd0, v} << 7);
            default: begin
                pts = pts | {25'd0, v[7:1]};
                if (!v[0]) pts_bad = 1'b1;
                if (pts_bad) pts = 32'd0;
            end
        endcase
    endtask

    function automatic logic audio_pick(input logic [7:0] n);
        if (audio_sel < 8'd192) return n == audio_sel;
        if (!auto_audio_set) begin
            auto_audio_set = 1'b1;
            auto_audio = n;
        end
        return n == auto_audio;
    endfunction

    function automatic logic video_pick(input logic [7:0] n);
        if (video_sel < 5'd16) return n == {3'd0, video_sel};
        if (!auto_video_set) begin
            auto_video_set = 1'b1;
            auto_video = n[3:0];
        end
        return n == {4'd0, auto_video};
    endfunction

    task automatic start_payload(input logic [1:0] k, input logic [7:0] n);
        out_kind = k;
        out_num  = n;
        count    = 4'd1;
        phase    = psd_pkg::PH_PAYLOAD;
    endtask

    task automatic header_end();
        if (is_mpeg2 && stream_id == 8'hBD) begin
            phase = psd_pkg::PH_SUBID;
            return;
        end
        if (stream_id >= 8'hC0 && stream_id <= 8'hDF) begin
            if (audio_pick(stream_id - 8'hC0)) begin
                start_payload(psd_pkg::KIND_AUDIO, stream_id - 8'hC0);
                return;
            end
        end else if (stream_id >= 8'hE0 && stream_id <= 8'hEF) begin
            if (video_pick(stream_id - 8'hE0)) begin
                start_payload(psd_pkg::KIND_VIDEO, stream_id - 8'hE0);
                return;
            end
        end
        phase = psd_pkg::PH_SKIP;
    endtask

    task automatic classify(input logic [7:0] v);
        if (v[7:4] == 4'h2 || v[7:4] == 4'h3) begin
            pts_byte(4'd0, v);
            has_dts = v[7:4] == 4'h3;
            count = 4'd1;
            phase = psd_pkg::PH_TS;
        end else if (v[7:6] == 2'd2) begin
            is_mpeg2 = 1'b1;
            phase = psd_pkg::PH_FLAGS;
        end else if (v == 8'h0F) begin
            header_end();
        end else begin
            restart_hunt();
        end
    endtask

    task automatic start_code(input logic [31:0] code);
        logic [7:0] low;
        window = psd_pkg::WINDOW_RESET;
        if (lock == psd_pkg::LK_NONE) begin
            if (code == 32'h1BA) lock = psd_pkg::LK_PACK;
        end else if (lock == psd_pkg::LK_PACK) begin
            if (code == 32'h1BB || code == 32'h1BD || (code >= 32'h1C0 && code <= 32'h1EF))
                lock = psd_pkg::LK_SYNC;
            else
                lock = psd_pkg::LK_NONE;
        end
        if (lock == psd_pkg::LK_SYNC) begin
            low = code[7:0];
            if (low < 8'hBC || low >= 8'hF0 || low == 8'hBE || low == 8'hBF) return;
            stream_id = low;
            phase = psd_pkg::PH_LEN_HI;
        end
    endtask

    task automatic step(input logic [7:0] v);
        psd_pkg::t_result r;
        case (phase)
            psd_pkg::PH_HUNT: begin
                window = {window[23:0], v};
                if (window[31:8] == 24'h000001) start_code(window);
            end
            psd_pkg::PH_LEN_HI: begin
                remaining = {v, 8'd0};
                phase = psd_pkg::PH_LEN_LO;
            end
            psd_pkg::PH_LEN_LO: begin
                remaining[7:0] = v;
                if (remaining == 16'd0) begin
                    restart_hunt();
                end else begin
                    pts = 32'd0;
                    pts_bad = 1'b0;
                    is_mpeg2 = 1'b0;
                    pts_flag = 1'b0;
                    phase = psd_pkg::PH_STUFF;
                end
            end
            psd_pkg::PH_STUFF: if (!consume() && v != 8'hFF) begin
                if (v[7:6] == 2'd1) phase = psd_pkg::PH_STD;
                else classify(v);
            end
            psd_pkg::PH_STD: if (!consume()) phase = psd_pkg::PH_CODE;
            psd_pkg::PH_CODE: if (!consume()) classify(v);
            psd_pkg::PH_TS: if (!consume()) begin
                pts_byte(count, v);
                count++;
                if (count >= 4'd5) begin
                    if (has_dts) begin
                        count = 4'd0;
                        phase = psd_pkg::PH_DTS1;
                    end else begin
                        header_end();
                    end
                end
            end
            psd_pkg::PH_DTS1: if (!consume()) begin
                if (count == 4'd0 && v[7:4] != 4'h1) pts = 32'd0;
                count++;
                if (count >= 4'd5) header_end();
            end
            psd_pkg::PH_FLAGS: if (!consume()) begin
                pts_flag = v[7];
                phase = psd_pkg::PH_HLEN;
            end
            psd_pkg::PH_HLEN: if (!consume()) begin
                if ({8'd0, v} > remaining) begin
                    restart_hunt();
                end else begin
                    hdr_remaining = v;
                    count = 4'd0;
                    if (v < 8'd5) pts_flag = 1'b0;
                    if (v == 8'd0) header_end();
                    else phase = psd_pkg::PH_HDR;
                end
            end
            psd_pkg::PH_HDR: if (!consume()) begin
                if (pts_flag && count < 4'd5) begin
                    pts_byte(count, v);
                    count++;
                end
                hdr_remaining--;
                if (hdr_remaining == 8'd0) header_end();
            end
            psd_pkg::PH_SUBID: if (!consume()) begin
                if (remaining < 16'd3) begin
                    restart_hunt();
                end else if (v[7:5] == 3'b001) begin
                    if (sub_sel < 6'd32 && {1'b0, v[4:0]} == sub_sel)
                        start_payload(psd_pkg::KIND_SUBTITLE, {3'd0, v[4:0]});
                    else
                        phase = psd_pkg::PH_SKIP;
                end else if (v[7:6] == 2'b10 && audio_pick(v)) begin
                    out_num = v;
                    is_lpcm = v[7:5] == 3'b101;
                    count = 4'd0;
                    phase = psd_pkg::PH_AUDHDR;
                end else begin
                    phase = psd_pkg::PH_SKIP;
                end
            end
            psd_pkg::PH_AUDHDR: if (!consume()) begin
                count++;
                if (count >= 4'd3) begin
                    if (is_lpcm && remaining >= 16'd2) begin
                        count = 4'd0;
                        pcm_marker = 16'd0;
                        phase = psd_pkg::PH_PCM;
                    end else begin
                        start_payload(psd_pkg::KIND_AUDIO, out_num);
                    end
                end
            end
            psd_pkg::PH_PCM: if (!consume()) begin
                pcm_marker = {pcm_marker[7:0], v};
                if (count < 4'd2) count++;
                if (count >= 4'd2 && pcm_marker == 16'h0180)
                    start_payload(psd_pkg::KIND_AUDIO, out_num);
            end
            psd_pkg::PH_PAYLOAD: begin
                remaining--;
                r.kind   = out_kind;
                r.number = out_num;
                r.data   = v;
                r.first  = count != 4'd0;
                r.stamp  = pts;
                r.last   = remaining == 16'd0;
                payload_q.push_back(r);
                count = 4'd0;
                if (r.last) restart_hunt();
            end
            psd_pkg::PH_SKIP: begin
                remaining--;
                if (remaining == 16'd0) restart_hunt();
            end
            default: restart_hunt();
        endcase
    endtask

    always @(posedge i_clk) begin
        psd_pkg::t_result want;
        if (!i_rst_n) begin
            audio_sel = 8'd192;
            video_sel = 5'd16;
            sub_sel = 6'd32;
            lock = psd_pkg::LK_NONE;
            window = psd_pkg::WINDOW_RESET;
            phase = psd_pkg::PH_HUNT;
            remaining = '0;
            hdr_remaining = '0;
            pts = '0;
            count = '0;
            stream_id = '0;
            auto_audio = '0;
            auto_audio_set = 1'b0;
            auto_video = '0;
            auto_video_set = 1'b0;
            pcm_marker = '0;
            pts_bad = 1'b0;
            has_dts = 1'b0;
            is_mpeg2 = 1'b0;
            pts_flag = 1'b0;
            is_lpcm = 1'b0;
            out_kind = '0;
            out_num = '0;
            payload_q.delete();
        end else begin
            if (i_pop && !i_empty) begin
                if (payload_q.size() == 0) begin
                    report("unexpected result", {24'd0, i_payload_byte}, 32'd0);
                end else begin
                    want = payload_q.pop_front();
                    if (i_stream_kind !== want.kind)
                        report("stream_kind", {30'd0, i_stream_kind}, {30'd0, want.kind});
                    if (i_stream_number !== want.number)
                        report("stream_number", {24'd0, i_stream_number}, {24'd0, want.number});
                    if (i_payload_byte !== want.data)
                        report("payload_byte", {24'd0, i_payload_byte}, {24'd0, want.data});
                    if (i_first_of_packet !== want.first)
                        report("first_of_packet", {31'd0, i_first_of_packet}, {31'd0, want.first});
                    if (i_stamp !== want.stamp)
                        report("stamp", i_stamp, want.stamp);
                    if (i_last_of_packet !== want.last)
                        report("last_of_packet", {31'd0, i_last_of_packet}, {31'd0, want.last});
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    psd_pkg::REG_AUDIO:    audio_sel = i_cfg_data;
                    psd_pkg::REG_VIDEO:    video_sel = i_cfg_data[4:0];
                    psd_pkg::REG_SUBTITLE: sub_sel = i_cfg_data[5:0];
                    default: ;
                endcase
            end
            if (i_push && !i_full) step(i_data_byte);
        end
    end

    initial o_errors = 0;

endmodule

@@ sim/testbench.sv @@
// Top of the demultiplexer testbench: builds program streams, drives the block and gives the verdict.
`timescale 1ns / 100ps
module testbench;

    localparam int LIMIT = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  i_data_byte = 8'd0;
    logic        empty;
    logic        pop = 1'b0;
    logic [1:0]  o_stream_kind;
    logic [7:0]  o_stream_number;
    logic [7:0]  o_payload_byte;
    logic        o_first_of_packet;
    logic [31:0] o_stamp;
    logic        o_last_of_packet;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = psd_pkg::REG_AUDIO;
    logic [7:0]  i_cfg_data = 8'd0;
    int          errors;
    int          pending;
    int          cycles = 0;
    bit          hold_off = 1'b0;
    logic [7:0]  stream_bytes[$];

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    program_stream_pes_demux i_dut (.*);

    psd_checker i_checker (
        .i_clk, .i_rst_n, .i_push(push), .i_full(full), .i_data_byte,
        .i_empty(empty), .i_pop(pop), .i_stream_kind(o_stream_kind),
        .i_stream_number(o_stream_number), .i_payload_byte(o_payload_byte),
        .i_first_of_packet(o_first_of_packet), .i_stamp(o_stamp),
        .i_last_of_packet(o_last_of_packet), .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .o_errors(errors), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // The receiver stalls in a pattern of its own, with one long hold-off.
    always @(posedge i_clk) begin
        int mode;
        mode = (cycles / 2000) % 3;
        if (hold_off) pop <= 1'b0;
        else if (mode == 0) pop <= 1'b1;
        else if (mode == 1) pop <= ($urandom_range(0, 3) != 0);
        else pop <= ($urandom_range(0, 3) == 0);
    end

    initial begin
        @(posedge i_rst_n);
        repeat (20) @(posedge i_clk);
        hold_off = 1'b1;
        repeat (300) @(posedge i_clk);
        hold_off = 1'b0;
    end

    task automatic add(input logic [7:0] b);
        stream_bytes.push_back(b);
    endtask

    task automatic add_code(input logic [7:0] id);
        add(8'h00); add(8'h00); add(8'h01); add(id);
    endtask

    task automatic add_pack();
        add_code(8'hBA);
        repeat (10) add(8'($urandom_range(0, 255)) | 8'h01);
    endtask

    task automatic add_pts(input logic [3:0] prefix, input bit bad);
        logic [32:0] p;
        p = {1'($urandom_range(0, 1)), $urandom};
        add({prefix, p[32:30], ~(bad && $urandom_range(0, 2) == 0)});
        add(p[29:22]);
        add({p[21:15], ~(bad && $urandom_range(0, 1) == 0)});
        add(p[14:7]);
        add({p[6:0], 1'b1});
    endtask

    // One PES packet with a random header of the given form and a payload of pay bytes.
    task automatic add_packet(input logic [7:0] id, input int pay, input int form,
                              input logic [7:0] sub);
        logic [7:0] hdr[$];
        logic [7:0] body[$];
        int         len;
        int         hl;
        logic [7:0] saved[$];
        saved = stream_bytes;
        stream_bytes = {};
        if (form == 0) begin
            repeat ($urandom_range(0, 2)) add(8'hFF);
            if ($urandom_range(0, 1)) begin
                add(8'h40 | 8'($urandom_range(0, 63))); add(8'($urandom));
            end
            case ($urandom_range(0, 2))
                0: add(8'h0F);
                1: add_pts(4'h2, $urandom_range(0, 3) == 0);
                default: begin
                    add_pts(4'h3, $urandom_range(0, 3) == 0);
                    add_pts(($urandom_range(0, 4) == 0) ? 4'h2 : 4'h1, 1'b0);
                end
            endcase
        end else begin
            add(8'h80 | 8'($urandom_range(0, 63)));
            hl = $urandom_range(0, 3);
            add({2'($urandom_range(0, 3)), 6'($urandom_range(0, 63))});
            if (hl == 0) begin
                add(8'd0);
            end else begin
                hl = (hl == 1) ? $urandom_range(1, 4) : $urandom_range(5, 9);
                add(8'(hl));
                if (hl >= 5) add_pts(4'h2, $urandom_range(0, 3) == 0);
                repeat (hl - ((hl >= 5) ? 5 : 0)) add(8'($urandom));
            end
            if (id == 8'hBD) begin
                add(sub);
                repeat (3) add(8'($urandom));
                if (sub[7:5] == 3'b101) begin
                    repeat ($urandom_range(0, 2)) add(8'($urandom));
                    add(8'h01); add(8'h80);
                end
            end
        end
        hdr = stream_bytes;
        body = {};
        repeat (pay) body.push_back(8'($urandom));
        len = hdr.size() + pay;
        if ($urandom_range(0, 30) == 0) len = $urandom_range(0, 3);
        stream_bytes = saved;
        add_code(id);
        add(8'(len >> 8));
        add(8'(len));
        foreach (hdr[i]) add(hdr[i]);
        foreach (body[i]) add(body[i]);
    endtask

    function automatic logic [7:0] random_id();
        case ($urandom_range(0, 5))
            0: return 8'hC0 + 8'($urandom_range(0, 31));
            1: return 8'hE0 + 8'($urandom_range(0, 15));
            2: return 8'hBD;
            3: return 8'hBB + 8'($urandom_range(0, 4));
            4: return 8'($urandom_range(0, 255));
            default: return 8'hC0 + 8'($urandom_range(0, 1));
        endcase
    endfunction

    function automatic logic [7:0] random_sub();
        case ($urandom_range(0, 3))
            0: return 8'h20 | 8'($urandom_range(0, 31));
            1: return 8'h80 + 8'($urandom_range(0, 3));
            2: return 8'hA0 + 8'($urandom_range(0, 1));
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_all();
        while (stream_bytes.size() != 0) begin
            if ($urandom_range(0, 3) == 0) begin
                push <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
            repeat ($urandom_range(1, 20)) begin
                if (stream_bytes.size() != 0) begin
                    push <= 1'b1;
                    i_data_byte <= stream_bytes.pop_front();
                    @(posedge i_clk);
                    while (full) @(posedge i_clk);
                end
            end
        end
        push <= 1'b0;
    endtask

    task automatic drain();
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic configure(input logic [1:0] idx, input logic [7:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int n;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: lock, each header form, drops, subtitles and LPCM.
        configure(psd_pkg::REG_SUBTITLE, 8'd5);
        add(8'h00); add(8'h00); add_pack();
        add_packet(8'hE3, 3, 1, 8'h00);
        add_packet(8'hC1, 2, 0, 8'h00);
        add_packet(8'hBD, 2, 1, 8'h25);
        add_packet(8'hBD, 2, 1, 8'hA0);
        add(8'h00); add(8'h00); add(8'h01); add(8'hE3); add(8'h00); add(8'h00);
        add_packet(8'hBC, 2, 1, 8'h00);
        add(8'hFF);
        send_all();
        drain();

        // Random phases over several register settings.
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin configure(psd_pkg::REG_AUDIO, 8'd0);
                          configure(psd_pkg::REG_VIDEO, 8'd0);
                          configure(psd_pkg::REG_SUBTITLE, 8'd0); end
                1: begin configure(psd_pkg::REG_AUDIO, 8'd128);
                          configure(psd_pkg::REG_VIDEO, 8'd15);
                          configure(psd_pkg::REG_SUBTITLE, 8'd31); end
                2: begin configure(psd_pkg::REG_AUDIO, 8'd255);
                          configure(psd_pkg::REG_VIDEO, 8'd31);
                          configure(psd_pkg::REG_SUBTITLE, 8'd63); end
                3: begin configure(psd_pkg::REG_AUDIO, 8'd1);
                          configure(psd_pkg::REG_VIDEO, 8'd16);
                          configure(psd_pkg::REG_SUBTITLE, 8'd32); end
                default: begin configure(psd_pkg::REG_AUDIO, 8'd192);
                          configure(psd_pkg::REG_VIDEO, 8'd1); end
            endcase
            n = 0;
            while (n < 5) begin
                if ($urandom_range(0, 6) == 0) add_pack();
                if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 6)) add(8'($urandom));
                add_packet(random_id(), $urandom_range(1, 12), $urandom_range(0, 1),
                           random_sub());
                n++;
                send_all();
            end
            drain();
        end

        if (errors == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

endmodule
